### rtl/core/trd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_pkg
// shared types, field positions and register indexes for trap redirection
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int XLEN = 64;

  // privilege levels
  localparam logic [1:0] PRV_U = 2'd0;
  localparam logic [1:0] PRV_S = 2'd1;

  // mstatus / vsstatus bit positions
  localparam int ST_SIE       = 1;
  localparam int ST_SPIE      = 5;
  localparam int ST_SPP       = 8;
  localparam int ST_MPP_LO    = 11;
  localparam int ST_MPP_HI    = 12;
  localparam int ST_SPELP     = 23;
  localparam int ST_MPV       = 39;
  localparam int ST_MPELP     = 41;

  // hstatus bit positions
  localparam int HS_GVA  = 6;
  localparam int HS_SPV  = 7;
  localparam int HS_SPVP = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HYP_DELEG  = 2'd0,
    CFG_S_VECTOR   = 2'd1,
    CFG_VS_VECTOR  = 2'd2,
    CFG_LPAD_EN    = 2'd3
  } trd_cfg_idx_t;

  // result codes
  localparam logic RES_REDIRECTED  = 1'b0;
  localparam logic RES_UNSUPPORTED = 1'b1;

  // stream packing
  localparam int IN_DATA_W  = 6 * XLEN;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 4 * XLEN;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic [XLEN-1:0] hyp_deleg_mask;
    logic [XLEN-1:0] s_vector_base;
    logic [XLEN-1:0] vs_vector_base;
    logic            landing_pad_enable;
  } trd_cfg_t;

  typedef struct packed {
    logic [XLEN-1:0] status_in;
    logic [XLEN-1:0] epc_in;
    logic [XLEN-1:0] cause_code;
    logic [XLEN-1:0] trap_value;
    logic [XLEN-1:0] trap_value2;
    logic [XLEN-1:0] trap_inst;
    logic            guest_va;
    logic            from_virt;
  } trd_item_t;

  typedef struct packed {
    logic [XLEN-1:0] hyp_status;
    logic [XLEN-1:0] vsup_status;
  } trd_state_t;

  typedef struct packed {
    logic            result_code;
    logic [XLEN-1:0] status_out;
    logic [XLEN-1:0] epc_out;
    logic            to_virt;
    logic [XLEN-1:0] hyp_status_out;
    logic [XLEN-1:0] vs_status_out;
  } trd_result_t;

  // state update request from the redirect logic
  typedef struct packed {
    logic       commit;
    trd_state_t state;
  } trd_update_t;

endpackage

### rtl/core/trap_redirect_delegation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trap_redirect_delegation
// forwards an m-mode trap to hs-mode or vs-mode using hedeleg (rv64, native h)
// ----------------------------------------------------------------------------
// Each input beat carries one trap taken into M-mode; one output beat comes
// back for it. A trap whose saved MPP is M or reserved returns result code 1
// with mstatus and mepc unchanged and no csr update. Otherwise it is sent to
// VS-mode when it came from virtual mode and its cause is a delegated
// exception below 64, else to HS-mode; the new mepc is the matching vector
// base. A trap passes through the input register and then the result register,
// from which its result beat is offered. One trap is accepted every cycle
// while the result stream does not stall; the figure is set by the
// hstatus/vsstatus images, which are updated in the same cycle a trap moves
// from the input register to the result register, so the next trap already
// sees them. Configuration writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module trap_redirect_delegation import trd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,

  // configuration write port
  input  logic                   wr_en,
  input  logic [CFG_IDX_W-1:0]   wr_index,
  input  logic [XLEN-1:0]        wr_data,

  // trap input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // status_in, epc_in, cause_code, trap_value, trap_value2, trap_inst
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // guest_va, from_virt
  input  logic [IN_USER_W-1:0]   s_tuser,

  // redirect result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status_out, epc_out, hyp_status_out, vs_status_out
  output logic [OUT_DATA_W-1:0]  m_tdata,
  // result_code, to_virt
  output logic [OUT_USER_W-1:0]  m_tuser
);

  trd_cfg_t    cfg;
  trd_state_t  cur;
  trd_item_t   item;
  logic        item_valid;
  trd_result_t res;
  trd_result_t res_q;
  trd_update_t upd;
  logic        res_valid;
  logic        advance;

  // the input register moves on whenever the result register is free or drains
  assign advance  = !res_valid || m_tready;
  assign s_tready = !item_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (trd_cfg_idx_t'(wr_index))
        CFG_HYP_DELEG: cfg.hyp_deleg_mask     <= wr_data;
        CFG_S_VECTOR:  cfg.s_vector_base      <= wr_data;
        CFG_VS_VECTOR: cfg.vs_vector_base     <= wr_data;
        CFG_LPAD_EN:   cfg.landing_pad_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.status_in   <= s_tdata[0*XLEN +: XLEN];
      item.epc_in      <= s_tdata[1*XLEN +: XLEN];
      item.cause_code  <= s_tdata[2*XLEN +: XLEN];
      item.trap_value  <= s_tdata[3*XLEN +: XLEN];
      item.trap_value2 <= s_tdata[4*XLEN +: XLEN];
      item.trap_inst   <= s_tdata[5*XLEN +: XLEN];
      item.guest_va    <= s_tuser[0];
      item.from_virt   <= s_tuser[1];
    end
  end

  trd_redirect u_redirect (
    .item (item),
    .cfg  (cfg),
    .cur  (cur),
    .res  (res),
    .upd  (upd)
  );

  // hstatus and vsstatus images, committed as the trap leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (advance && item_valid && upd.commit) begin
      cur <= upd.state;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      res_q <= res;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {res_q.vs_status_out, res_q.hyp_status_out,
                     res_q.epc_out, res_q.status_out};
  assign m_tuser  = {res_q.to_virt, res_q.result_code};

endmodule

### rtl/core/trd_redirect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_redirect
// combinational trap delegation decision and csr image update
// ----------------------------------------------------------------------------
module trd_redirect import trd_pkg::*; (
  input  trd_item_t   item,
  input  trd_cfg_t    cfg,
  input  trd_state_t  cur,
  output trd_result_t res,
  output trd_update_t upd
);

  logic [1:0]      pmode;
  logic            unsupported;
  logic            prev_s;
  logic            elp;
  logic            small_cause;
  logic            nvirt;
  logic [XLEN-1:0] st;
  logic [XLEN-1:0] h;
  logic [XLEN-1:0] vs;

  always_comb begin
    pmode       = item.status_in[ST_MPP_HI:ST_MPP_LO];
    unsupported = (pmode != PRV_S) && (pmode != PRV_U);
    prev_s      = (pmode == PRV_S);
    elp         = cfg.landing_pad_enable & item.status_in[ST_MPELP];
    small_cause = (item.cause_code[XLEN-1:$clog2(XLEN)] == '0);
    nvirt       = item.from_virt && small_cause &&
                  cfg.hyp_deleg_mask[item.cause_code[$clog2(XLEN)-1:0]];

    st = item.status_in;
    if (cfg.landing_pad_enable) begin
      st[ST_MPELP] = 1'b0;
    end
    st[ST_MPV]              = nvirt;
    st[ST_MPP_HI:ST_MPP_LO] = PRV_S;

    // hstatus only changes on the hs path
    h = cur.hyp_status;
    if (!nvirt) begin
      if (item.from_virt) begin
        h[HS_SPVP] = prev_s;
      end
      h[HS_SPV] = item.from_virt;
      h[HS_GVA] = item.guest_va;
    end

    vs = cur.vsup_status;
    if (nvirt) begin
      if (elp) begin
        vs[ST_SPELP] = 1'b1;
      end
      vs[ST_SPP]  = prev_s;
      vs[ST_SPIE] = vs[ST_SIE];
      vs[ST_SIE]  = 1'b0;
    end else begin
      st[ST_SPP]  = prev_s;
      st[ST_SPIE] = st[ST_SIE];
      st[ST_SIE]  = 1'b0;
      if (elp) begin
        st[ST_SPELP] = 1'b1;
      end
    end

    if (unsupported) begin
      res.result_code    = RES_UNSUPPORTED;
      res.status_out     = item.status_in;
      res.epc_out        = item.epc_in;
      res.to_virt        = 1'b0;
      res.hyp_status_out = cur.hyp_status;
      res.vs_status_out  = cur.vsup_status;
    end else begin
      res.result_code    = RES_REDIRECTED;
      res.status_out     = st;
      res.epc_out        = nvirt ? cfg.vs_vector_base : cfg.s_vector_base;
      res.to_virt        = nvirt;
      res.hyp_status_out = h;
      res.vs_status_out  = vs;
    end

    upd.commit            = !unsupported;
    upd.state.hyp_status  = h;
    upd.state.vsup_status = vs;
  end

endmodule

### rtl/core/trd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_checker
// port-level checks on the redirect result stream
// ----------------------------------------------------------------------------
module trd_checker import trd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_DATA_W-1:0]  m_tdata,
  input  logic [OUT_USER_W-1:0]  m_tuser
);

  // an unsupported trap is never delivered to vs
  a_unsup_not_virt: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] == RES_UNSUPPORTED) |-> !m_tuser[1])
    else $error("unsupported trap flagged as vs delivery");

  // unsupported traps echo an mstatus whose mpp is m or reserved
  a_unsup_mpp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] == RES_UNSUPPORTED) |-> m_tdata[ST_MPP_HI])
    else $error("unsupported result with s or u previous mode");

  // redirected traps bound for hs land with mpp = s, mpv = 0 and sie clear; vs-bound beats pass unchecked
  a_redirect_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] == RES_REDIRECTED) |->
      (m_tdata[ST_MPP_HI:ST_MPP_LO] == PRV_S && m_tdata[ST_MPV] == m_tuser[1]
       && !m_tdata[ST_SIE] || m_tuser[1]))
    else $error("redirected mstatus malformed");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result beat changed while stalled");

  // no result beat right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind trap_redirect_delegation trd_checker u_trd_checker (.*);

### dv/trap_redirect_delegation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trap_redirect_delegation_tb
// self-checking bench for m-mode trap redirection to hs-mode or vs-mode
// ----------------------------------------------------------------------------
// Traps are queued by the sequence block and sent by a driver that moves on
// the falling edge. The monitor samples on the rising edge. For every trap
// beat it accepts, a bit-accurate model works out the redirect outcome and
// keeps its own hstatus/vsstatus copy. Result beats are compared field by
// field, in order, with those predictions. A short directed set covers
// unsupported modes, both delegation paths, landing pads and large causes.
// Six random segments follow, each under its own register setting, with the
// backpressure mix changing every second segment.
// ----------------------------------------------------------------------------
module trap_redirect_delegation_tb;
  import trd_pkg::*;

  localparam int SEG_ITEMS   = 238;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;

  // saved previous modes the block refuses to forward
  localparam logic [1:0] PRV_RSVD = 2'd2;
  localparam logic [1:0] PRV_M    = 2'd3;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [XLEN-1:0]       wr_data  = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // status_in, epc_in, cause_code, trap_value, trap_value2, trap_inst
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  // guest_va, from_virt
  logic [IN_USER_W-1:0]  s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // status_out, epc_out, hyp_status_out, vs_status_out
  logic [OUT_DATA_W-1:0] m_tdata;
  // result_code, to_virt
  logic [OUT_USER_W-1:0] m_tuser;

  trap_redirect_delegation dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // traps waiting to be sent, and redirect outcomes waiting to come back
  trd_item_t   trap_q[$];
  trd_result_t redirect_q[$];
  trd_item_t   in_trap;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned err_count    = 0;
  int unsigned stall_cycles = 0;
  logic        in_fire      = 1'b0;

  // model copy of the registers and the trap csrs
  trd_cfg_t        model_cfg = '0;
  logic [XLEN-1:0] hyp_status, hyp_tval, hyp_tinst;
  logic [XLEN-1:0] sup_tval, sup_epc, sup_cause;
  logic [XLEN-1:0] vsup_tval, vsup_epc, vsup_cause, vsup_status;

  initial begin
    hyp_status = '0; hyp_tval = '0; hyp_tinst = '0;
    sup_tval = '0; sup_epc = '0; sup_cause = '0;
    vsup_tval = '0; vsup_epc = '0; vsup_cause = '0; vsup_status = '0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] with_mpp(logic [63:0] st, logic [1:0] mode);
    st[ST_MPP_HI:ST_MPP_LO] = mode;
    return st;
  endfunction

  // works out one redirect and advances the model csrs
  function automatic trd_result_t redirect_trap(trd_item_t t);
    trd_result_t r;
    logic [XLEN-1:0] st;
    logic [XLEN-1:0] hs;
    logic [XLEN-1:0] vs;
    logic [1:0]      pmode;
    logic            elp;
    logic            nvirt;
    st    = t.status_in;
    pmode = st[ST_MPP_HI:ST_MPP_LO];
    elp   = 1'b0;
    r     = '0;
    r.hyp_status_out = hyp_status;
    r.vs_status_out  = vsup_status;
    // previous mode m or reserved: echo the inputs, touch nothing
    if (pmode != PRV_S && pmode != PRV_U) begin
      r.result_code = RES_UNSUPPORTED;
      r.status_out  = st;
      r.epc_out     = t.epc_in;
      return r;
    end
    if (model_cfg.landing_pad_enable) begin
      elp = st[ST_MPELP];
      st[ST_MPELP] = 1'b0;
    end
    // interrupts and causes of 64 or more never reach vs
    nvirt = t.from_virt && (t.cause_code < 64'(XLEN)) &&
            model_cfg.hyp_deleg_mask[t.cause_code[5:0]];
    st[ST_MPV] = nvirt;
    if (!nvirt) begin
      hs = hyp_status;
      if (t.from_virt)
        hs[HS_SPVP] = (pmode == PRV_S);
      hs[HS_SPV] = t.from_virt;
      hs[HS_GVA] = t.guest_va;
      hyp_status = hs;
      hyp_tval   = t.trap_value2;
      hyp_tinst  = t.trap_inst;
    end
    st[ST_MPP_HI:ST_MPP_LO] = PRV_S;
    if (nvirt) begin
      vs = vsup_status;
      vsup_tval  = t.trap_value;
      vsup_epc   = t.epc_in;
      vsup_cause = t.cause_code;
      r.epc_out  = model_cfg.vs_vector_base;
      if (elp)
        vs[ST_SPELP] = 1'b1;
      vs[ST_SPP]  = (pmode == PRV_S);
      vs[ST_SPIE] = vs[ST_SIE];
      vs[ST_SIE]  = 1'b0;
      vsup_status = vs;
    end else begin
      sup_tval  = t.trap_value;
      sup_epc   = t.epc_in;
      sup_cause = t.cause_code;
      r.epc_out = model_cfg.s_vector_base;
      st[ST_SPP]  = (pmode == PRV_S);
      st[ST_SPIE] = st[ST_SIE];
      st[ST_SIE]  = 1'b0;
      if (elp)
        st[ST_SPELP] = 1'b1;
    end
    r.result_code    = RES_REDIRECTED;
    r.status_out     = st;
    r.to_virt        = nvirt;
    r.hyp_status_out = hyp_status;
    r.vs_status_out  = vsup_status;
    return r;
  endfunction

  function automatic trd_item_t make_trap(logic [63:0] st, logic [63:0] cause,
                                          logic [63:0] fill, logic gva, logic fv);
    trd_item_t t;
    t.status_in   = st;
    t.epc_in      = fill;
    t.cause_code  = cause;
    t.trap_value  = fill;
    t.trap_value2 = fill;
    t.trap_inst   = fill;
    t.guest_va    = gva;
    t.from_virt   = fv;
    return t;
  endfunction

  // random trap: mostly s/u previous mode and causes below 64 so that the
  // delegation mask gets exercised, the rest refused modes and odd causes
  function automatic trd_item_t rand_trap();
    trd_item_t t;
    logic [63:0] cause;
    logic [1:0]  mode;
    case ($urandom_range(19))
      0:       mode = PRV_M;
      1:       mode = PRV_RSVD;
      default: mode = $urandom_range(1) ? PRV_S : PRV_U;
    endcase
    case ($urandom_range(9))
      7:       cause = {1'b1, 57'd0, 6'($urandom_range(63))};
      8:       cause = 64'(XLEN) + 64'($urandom_range(3));
      9:       cause = rand64();
      default: cause = 64'($urandom_range(63));
    endcase
    t = make_trap(with_mpp(rand64(), mode), cause, rand64(), 1'($urandom_range(1)),
                  $urandom_range(9) < 7);
    t.epc_in      = rand64();
    t.trap_value2 = rand64();
    t.trap_inst   = rand64();
    return t;
  endfunction

  // registers are only written while nothing is in flight
  task automatic apply_cfg(trd_cfg_t c);
    logic [XLEN-1:0] val;
    for (int i = 0; i < 4; i++) begin
      case (trd_cfg_idx_t'(i))
        CFG_HYP_DELEG: val = c.hyp_deleg_mask;
        CFG_S_VECTOR:  val = c.s_vector_base;
        CFG_VS_VECTOR: val = c.vs_vector_base;
        default: begin
          // upper bits are don't care for the enable
          val    = rand64();
          val[0] = c.landing_pad_enable;
        end
      endcase
      @(negedge clk);
      wr_en    <= 1'b1;
      wr_index <= trd_cfg_idx_t'(i);
      wr_data  <= val;
    end
    @(negedge clk);
    wr_en <= 1'b0;
    model_cfg = c;
  endtask

  task automatic wait_drained();
    while (trap_q.size() != 0 || s_tvalid || redirect_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (err_count < MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // trap driver: holds a beat until it is taken, then maybe idles
  always @(negedge clk) begin
    trd_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (trap_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = trap_q.pop_front();
        in_trap  <= nxt;
        s_tvalid <= 1'b1;
        s_tdata  <= {nxt.trap_inst, nxt.trap_value2, nxt.trap_value,
                     nxt.cause_code, nxt.epc_in, nxt.status_in};
        s_tuser  <= {nxt.from_virt, nxt.guest_va};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random backpressure
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= snk_idle_pct);
  end

  // monitor: check result beats first, then predict the trap beat taken now
  always @(posedge clk) begin
    trd_result_t want;
    logic out_fire;
    in_fire  = s_tvalid && s_tready;
    out_fire = m_tvalid && m_tready;
    if (!rst && out_fire) begin
      if (redirect_q.size() == 0) begin
        flag_mismatch("unexpected result beat", m_tdata[63:0], '0);
      end else begin
        want = redirect_q.pop_front();
        if (m_tuser[0] !== want.result_code)
          flag_mismatch("result_code", 64'(m_tuser[0]), 64'(want.result_code));
        if (m_tuser[1] !== want.to_virt)
          flag_mismatch("to_virt", 64'(m_tuser[1]), 64'(want.to_virt));
        if (m_tdata[63:0] !== want.status_out)
          flag_mismatch("status_out", m_tdata[63:0], want.status_out);
        if (m_tdata[127:64] !== want.epc_out)
          flag_mismatch("epc_out", m_tdata[127:64], want.epc_out);
        if (m_tdata[191:128] !== want.hyp_status_out)
          flag_mismatch("hyp_status_out", m_tdata[191:128], want.hyp_status_out);
        if (m_tdata[255:192] !== want.vs_status_out)
          flag_mismatch("vs_status_out", m_tdata[255:192], want.vs_status_out);
      end
    end
    if (!rst && in_fire)
      redirect_q.push_back(redirect_trap(in_trap));
    if (in_fire || out_fire)
      stall_cycles = 0;
    else
      stall_cycles++;
  end

  // watchdog on cycles with no beat moving on either side
  initial begin
    while (stall_cycles < STALL_LIMIT)
      @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // sequence: directed traps, then random segments under changing settings
  initial begin
    trd_cfg_t c;
    logic [63:0] ones;
    logic [63:0] lp;
    ones = '1;
    lp   = 64'd1 << ST_MPELP;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // delegate causes 2, 9, 11 and 63 only
    c.hyp_deleg_mask     = 64'h8000_0000_0000_0A04;
    c.s_vector_base      = 64'h0000_0000_8000_0100;
    c.vs_vector_base     = 64'h0000_0000_8020_0200;
    c.landing_pad_enable = 1'b1;
    apply_cfg(c);

    trap_q.push_back(make_trap('0, '0, '0, 1'b0, 1'b0));
    // previous mode m, then reserved
    trap_q.push_back(make_trap(ones, 64'd2, ones, 1'b1, 1'b1));
    trap_q.push_back(make_trap(with_mpp(ones, PRV_RSVD), 64'd2, ones, 1'b1, 1'b1));
    // vs path from s with landing pad pending and sie set
    trap_q.push_back(make_trap(with_mpp(ones, PRV_S), 64'd2, ones, 1'b1, 1'b1));
    // vs path from u, sie clear
    trap_q.push_back(make_trap(with_mpp(lp, PRV_U), 64'd9, 64'h1234, 1'b0, 1'b1));
    trap_q.push_back(make_trap(with_mpp(ones, PRV_S), 64'd63, ones, 1'b0, 1'b1));
    // delegated cause but not virtual: hs path, landing pad lands in mstatus
    trap_q.push_back(make_trap(with_mpp(lp | 64'h2, PRV_S), 64'd2, ones, 1'b0, 1'b0));
    // hs path from virtual s and virtual u: spvp set then cleared
    trap_q.push_back(make_trap(with_mpp(64'h2, PRV_S), 64'd5, 64'h55, 1'b1, 1'b1));
    trap_q.push_back(make_trap(with_mpp('0, PRV_U), 64'd5, 64'haa, 1'b0, 1'b1));
    // causes at and above 64, interrupt with a delegated code
    trap_q.push_back(make_trap(with_mpp(ones, PRV_S), 64'(XLEN), ones, 1'b1, 1'b1));
    trap_q.push_back(make_trap(with_mpp(ones, PRV_U), {1'b1, 61'd0, 2'd2}, '0,
                               1'b0, 1'b1));
    trap_q.push_back(make_trap(with_mpp('0, PRV_S), ones, ones, 1'b1, 1'b1));
    trap_q.push_back(make_trap(with_mpp(64'hA5A5_5A5A_0F0F_F0F0, PRV_S), 64'd11,
                               64'h5A5A_A5A5_F0F0_0F0F, 1'b0, 1'b1));
    // refused mode after state has moved: csr images must read back as is
    trap_q.push_back(make_trap(with_mpp('0, PRV_M), 64'd2, '0, 1'b0, 1'b1));
    wait_drained();

    for (int seg = 0; seg < 6; seg++) begin
      // give the pipe time before the next register setting
      repeat (4) @(posedge clk);
      c.hyp_deleg_mask     = rand64();
      c.s_vector_base      = rand64();
      c.vs_vector_base     = rand64();
      c.landing_pad_enable = seg[0] ^ seg[1];
      case (seg)
        0: begin
          c.hyp_deleg_mask = ones;
          c.s_vector_base  = '0;
          c.vs_vector_base = ones;
        end
        2: begin
          c.hyp_deleg_mask = '0;
          c.s_vector_base  = ones;
          c.vs_vector_base = '0;
        end
        5: c.hyp_deleg_mask = ones;
        default: ;
      endcase
      apply_cfg(c);
      // sender idles lightly, then receiver, then neither
      case (seg / 2)
        0: begin
          src_idle_pct = 10;
          snk_idle_pct = 63;
        end
        1: begin
          src_idle_pct = 63;
          snk_idle_pct = 10;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < SEG_ITEMS; i++)
        trap_q.push_back(rand_trap());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
